@@ rtl/strict_priority_message_queue_assert.svh @@
// assertion macros for the strict priority message queue
// expects a clock named clock and a reset named reset in the using module
`ifndef STRICT_PRIORITY_MESSAGE_QUEUE_ASSERT_SVH
`define STRICT_PRIORITY_MESSAGE_QUEUE_ASSERT_SVH

// same-cycle implication
`define SPMQ_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SPMQ_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/spmq_pkg.sv @@
// shared constants for the strict priority message queue
// no dependencies
`default_nettype none

package spmq_pkg;

   localparam int LEVELS_DEFAULT       = 4;
   localparam int CAPACITY_DEFAULT     = 64;
   localparam int PAYLOAD_BITS_DEFAULT = 32;

   localparam int ACTION_BITS    = 2;
   localparam int PRIORITY_BITS  = 3;
   localparam int STATUS_BITS    = 2;
   localparam int LEVEL_OUT_BITS = 2;
   localparam int TOTAL_BITS     = 32;
   localparam int MAX_COUNT_BITS = 7;

   localparam logic [MAX_COUNT_BITS-1:0] MAX_COUNT_RESET = 7'd64;

   localparam logic [ACTION_BITS-1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_DEQUEUE = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_FLUSH   = 2'd2;

   localparam logic [STATUS_BITS-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_DROPPED = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_EMPTY   = 2'd2;

endpackage

`default_nettype wire

@@ rtl/spmq_ram.sv @@
// generic simple dual port ram with registered read
// no dependencies
`default_nettype none

module spmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/strict_priority_message_queue.sv @@
// strict priority message queue: per-level linked fifos over one shared slot store
// depends on spmq_pkg, spmq_ram and strict_priority_message_queue_assert.svh
//
// usage:
//   req channel carries one transaction per command: enqueue (action, priority_req,
//   payload), dequeue, or flush of all levels. rsp channel returns exactly one
//   transaction per command with status, dequeued payload and level, occupancy and
//   the three wrapping totals. csr channel writes max_count (zero: capacity only);
//   write it only while the block is idle.
//   each command is accepted in the idle state, which reads the link and payload
//   memories; the execute state then modifies and writes them back and loads the
//   response register. a new command is accepted only once the previous one has
//   left execute. if the receiver stalls, one finished response waits in the
//   output register and the next command may still be accepted; that command
//   then holds in its execute state until the output register frees.
//   reset is synchronous; no clearing pass is needed since never-allocated slots
//   are tracked by an allocation watermark, so the block is ready right after reset.
//   flush keeps the totals.
`default_nettype none
`include "strict_priority_message_queue_assert.svh"

module strict_priority_message_queue #(
   parameter int LEVELS       = spmq_pkg::LEVELS_DEFAULT,
   parameter int CAPACITY     = spmq_pkg::CAPACITY_DEFAULT,
   parameter int PAYLOAD_BITS = spmq_pkg::PAYLOAD_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [spmq_pkg::ACTION_BITS-1:0]      req_action,
   input  wire logic [spmq_pkg::PRIORITY_BITS-1:0]    req_priority_req,
   input  wire logic [PAYLOAD_BITS-1:0]               req_payload,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [spmq_pkg::STATUS_BITS-1:0]           rsp_status,
   output logic [PAYLOAD_BITS-1:0]                    rsp_payload_out,
   output logic [spmq_pkg::LEVEL_OUT_BITS-1:0]        rsp_level_out,
   output logic [$clog2(CAPACITY+1)-1:0]              rsp_occupancy,
   output logic [spmq_pkg::TOTAL_BITS-1:0]            rsp_total_enqueued,
   output logic [spmq_pkg::TOTAL_BITS-1:0]            rsp_total_dequeued,
   output logic [spmq_pkg::TOTAL_BITS-1:0]            rsp_total_dropped,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [spmq_pkg::MAX_COUNT_BITS-1:0]   csr_max_count
);

   localparam int SLOT_BITS  = $clog2(CAPACITY);
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int LEVEL_BITS = $clog2(LEVELS);
   localparam int CMP_BITS   = (COUNT_BITS > spmq_pkg::MAX_COUNT_BITS) ?
                               COUNT_BITS : spmq_pkg::MAX_COUNT_BITS;
   localparam int TB         = spmq_pkg::TOTAL_BITS;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   typedef struct packed {
      logic [spmq_pkg::ACTION_BITS-1:0] action;
      logic [LEVEL_BITS-1:0]            lvl;
      logic [SLOT_BITS-1:0]             slot;
      logic                             full;
      logic                             found;
      logic [PAYLOAD_BITS-1:0]          word;
   } stage_type;

   state_type                           state_ff, state_in;
   stage_type                           stage_ff;
   logic [SLOT_BITS-1:0]                heads_ff [LEVELS];
   logic [SLOT_BITS-1:0]                heads_in [LEVELS];
   logic [SLOT_BITS-1:0]                tails_ff [LEVELS];
   logic [SLOT_BITS-1:0]                tails_in [LEVELS];
   logic [LEVELS-1:0]                   nonempty_ff, nonempty_in;
   logic [SLOT_BITS-1:0]                free_head_ff, free_head_in;
   logic [COUNT_BITS-1:0]               held_ff, held_in;
   logic [COUNT_BITS-1:0]               fresh_ff, fresh_in;
   logic [TB-1:0]                       enq_total_ff, enq_total_in;
   logic [TB-1:0]                       deq_total_ff, deq_total_in;
   logic [TB-1:0]                       drop_total_ff, drop_total_in;
   logic [spmq_pkg::MAX_COUNT_BITS-1:0] max_count_ff;

   logic                                rsp_valid_ff;
   logic [spmq_pkg::STATUS_BITS-1:0]    rsp_status_ff, rsp_status_in;
   logic [PAYLOAD_BITS-1:0]             rsp_payload_ff, rsp_payload_in;
   logic [spmq_pkg::LEVEL_OUT_BITS-1:0] rsp_level_ff, rsp_level_in;

   logic                                req_fire;
   logic                                exec_fire;
   logic [LEVEL_BITS-1:0]               enq_lvl;
   logic [LEVEL_BITS-1:0]               deq_lvl;
   logic                                deq_found;
   logic                                enq_full;
   logic [SLOT_BITS-1:0]                link_rd_addr;
   logic [SLOT_BITS-1:0]                link_rd_data;
   logic [PAYLOAD_BITS-1:0]             pay_rd_data;
   logic                                slot_fresh;
   logic [SLOT_BITS-1:0]                slot_succ;
   logic [SLOT_BITS-1:0]                link_next;
   logic                                link_wr_en;
   logic [SLOT_BITS-1:0]                link_wr_addr;
   logic [SLOT_BITS-1:0]                link_wr_data;
   logic                                pay_wr_en;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign exec_fire = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;

   // issue-cycle decode
   always_comb begin
      deq_lvl = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            deq_lvl = LEVEL_BITS'(i);
         end
      end
   end

   assign deq_found = (|nonempty_ff) && (held_ff != '0);
   assign enq_lvl   = (int'(req_priority_req) >= LEVELS) ? LEVEL_BITS'(LEVELS - 1) :
                      LEVEL_BITS'(req_priority_req);
   assign enq_full  = ((max_count_ff != '0) &&
                       (CMP_BITS'(held_ff) >= CMP_BITS'(max_count_ff))) ||
                      (held_ff >= COUNT_BITS'(CAPACITY));
   assign link_rd_addr = (req_action == spmq_pkg::ACT_ENQUEUE) ? free_head_ff :
                         heads_ff[deq_lvl];

   spmq_ram #(
      .WIDTH (SLOT_BITS),
      .DEPTH (CAPACITY)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (req_fire),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data)
   );

   spmq_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (CAPACITY)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (pay_wr_en),
      .wr_addr (stage_ff.slot),
      .wr_data (stage_ff.word),
      .rd_en   (req_fire),
      .rd_addr (heads_ff[deq_lvl]),
      .rd_data (pay_rd_data)
   );

   // slots at or above the watermark were never allocated; their link is the next slot, wrapping to zero
   assign slot_fresh = (COUNT_BITS'(stage_ff.slot) >= fresh_ff);
   assign slot_succ  = (stage_ff.slot == SLOT_BITS'(CAPACITY - 1)) ? '0 :
                       stage_ff.slot + 1'b1;
   assign link_next  = slot_fresh ? slot_succ : link_rd_data;

   // execute cycle: modify and write back
   always_comb begin
      heads_in       = heads_ff;
      tails_in       = tails_ff;
      nonempty_in    = nonempty_ff;
      free_head_in   = free_head_ff;
      held_in        = held_ff;
      fresh_in       = fresh_ff;
      enq_total_in   = enq_total_ff;
      deq_total_in   = deq_total_ff;
      drop_total_in  = drop_total_ff;
      rsp_status_in  = spmq_pkg::STAT_OK;
      rsp_payload_in = '0;
      rsp_level_in   = '0;
      link_wr_en     = 1'b0;
      link_wr_addr   = stage_ff.slot;
      link_wr_data   = free_head_ff;
      pay_wr_en      = 1'b0;
      case (stage_ff.action)
         spmq_pkg::ACT_ENQUEUE: begin
            if (stage_ff.full) begin
               drop_total_in = drop_total_ff + 1'b1;
               rsp_status_in = spmq_pkg::STAT_DROPPED;
            end else begin
               free_head_in = link_next;
               pay_wr_en    = 1'b1;
               if (nonempty_ff[stage_ff.lvl]) begin
                  link_wr_en   = 1'b1;
                  link_wr_addr = tails_ff[stage_ff.lvl];
                  link_wr_data = stage_ff.slot;
               end else begin
                  heads_in[stage_ff.lvl] = stage_ff.slot;
               end
               tails_in[stage_ff.lvl]    = stage_ff.slot;
               nonempty_in[stage_ff.lvl] = 1'b1;
               held_in                   = held_ff + 1'b1;
               enq_total_in              = enq_total_ff + 1'b1;
               if (slot_fresh) begin
                  fresh_in = fresh_ff + 1'b1;
               end
            end
         end
         spmq_pkg::ACT_DEQUEUE: begin
            if (!stage_ff.found) begin
               rsp_status_in = spmq_pkg::STAT_EMPTY;
            end else begin
               rsp_payload_in = pay_rd_data;
               rsp_level_in   = spmq_pkg::LEVEL_OUT_BITS'(stage_ff.lvl);
               if (tails_ff[stage_ff.lvl] == stage_ff.slot) begin
                  nonempty_in[stage_ff.lvl] = 1'b0;
               end else begin
                  heads_in[stage_ff.lvl] = link_next;
               end
               link_wr_en   = 1'b1;
               free_head_in = stage_ff.slot;
               held_in      = held_ff - 1'b1;
               deq_total_in = deq_total_ff + 1'b1;
            end
         end
         spmq_pkg::ACT_FLUSH: begin
            for (int i = 0; i < LEVELS; i++) begin
               heads_in[i] = '0;
               tails_in[i] = '0;
            end
            nonempty_in  = '0;
            free_head_in = '0;
            held_in      = '0;
            fresh_in     = '0;
         end
         default: begin
         end
      endcase
      if (!exec_fire) begin
         link_wr_en = 1'b0;
         pay_wr_en  = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         nonempty_ff   <= '0;
         free_head_ff  <= '0;
         held_ff       <= '0;
         fresh_ff      <= '0;
         enq_total_ff  <= '0;
         deq_total_ff  <= '0;
         drop_total_ff <= '0;
         max_count_ff  <= spmq_pkg::MAX_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            heads_ff[i] <= '0;
            tails_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            max_count_ff <= csr_max_count;
         end
         if (exec_fire) begin
            heads_ff      <= heads_in;
            tails_ff      <= tails_in;
            nonempty_ff   <= nonempty_in;
            free_head_ff  <= free_head_in;
            held_ff       <= held_in;
            fresh_ff      <= fresh_in;
            enq_total_ff  <= enq_total_in;
            deq_total_ff  <= deq_total_in;
            drop_total_ff <= drop_total_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_ff.action <= req_action;
         stage_ff.lvl    <= (req_action == spmq_pkg::ACT_ENQUEUE) ? enq_lvl : deq_lvl;
         stage_ff.slot   <= link_rd_addr;
         stage_ff.full   <= enq_full;
         stage_ff.found  <= deq_found;
         stage_ff.word   <= req_payload;
      end
      if (exec_fire) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_payload_ff <= rsp_payload_in;
         rsp_level_ff   <= rsp_level_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_payload_out    = rsp_payload_ff;
   assign rsp_level_out      = rsp_level_ff;
   assign rsp_occupancy      = held_ff;
   assign rsp_total_enqueued = enq_total_ff;
   assign rsp_total_dequeued = deq_total_ff;
   assign rsp_total_dropped  = drop_total_ff;

   `SPMQ_ASSERT_SAME(a_held_bound, 1'b1, held_ff <= COUNT_BITS'(CAPACITY),
      "occupancy above capacity")
   `SPMQ_ASSERT_SAME(a_empty_levels, held_ff == '0, nonempty_ff == '0,
      "level marked nonempty with zero occupancy")
   `SPMQ_ASSERT_SAME(a_watermark, 1'b1, fresh_ff >= held_ff,
      "more slots held than ever allocated")
   `SPMQ_ASSERT_NEXT(a_accept_exec, req_valid && req_ready, state_ff == ST_EXEC,
      "accepted transaction did not enter execute")

endmodule

`default_nettype wire
